### rtl/mcs_pkg.sv
// shared constants, types and codes of the 3d maze carving step block
package mcs_pkg;

	// grid geometry
	localparam int MAX_SIDE   = 32;
	localparam int COORD_W    = 5;
	localparam int SIZE_W     = 6;
	localparam int CELL_DEPTH = MAX_SIDE * MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W     = $clog2(CELL_DEPTH);

	// cell memory is organized as rows of 32 one-bit cells
	localparam int BIT_W      = 5;
	localparam int ROW_BITS   = 1 << BIT_W;
	localparam int ROW_AW     = ADDR_W - BIT_W;
	localparam int ROW_DEPTH  = CELL_DEPTH / ROW_BITS;

	// commands
	localparam logic [1:0] CMD_STEP = 2'd0;
	localparam logic [1:0] CMD_SET  = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;
	localparam logic [1:0] CMD_NOP  = 2'd3;

	// register indexes
	localparam logic [1:0] REG_SIZE_X = 2'd0;
	localparam logic [1:0] REG_SIZE_Y = 2'd1;
	localparam logic [1:0] REG_SIZE_Z = 2'd2;

	// request to the cell memory
	typedef struct packed {
		logic              rd;
		logic              set;
		logic              clr;
		logic [ADDR_W-1:0] addr;
	} mem_req_t;

endpackage

### rtl/mcs_cell_ram.sv
// single-port cell memory: bit set, row clear and registered bit read
module mcs_cell_ram
	import mcs_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output logic     rdata
);

	logic [ROW_BITS-1:0] mem [ROW_DEPTH];
	logic                rd_q;

	logic [ROW_AW-1:0] row;
	logic [BIT_W-1:0]  bit_sel;

	assign row     = req.addr[ADDR_W-1:BIT_W];
	assign bit_sel = req.addr[BIT_W-1:0];

	// write port: clear a whole row or set one cell
	always_ff @(posedge clk) begin
		if (req.clr) begin
			mem[row] <= '0;
		end else if (req.set) begin
			mem[row][bit_sel] <= 1'b1;
		end
	end

	// read port, registered, holds between reads
	always_ff @(posedge clk) begin
		if (req.rd) begin
			rd_q <= mem[row][bit_sel];
		end
	end

	assign rdata = rd_q;

endmodule

### rtl/maze_carve_step_3d.sv
// top level of the 3d maze carving step block
// After reset the block clears its cell memory one row of 32 cells per cycle, all 1024 rows,
// and accepts no beat meanwhile (size registers can be written). A carve step runs from
// the accepted beat through address arithmetic, a dispatch state, pipelined neighbour
// reads, a modulo state, a select state, two cell writes and the result state, which
// waits while the output still holds an earlier result, back to the idle state that takes
// the next beat. A step that finds no open neighbour skips select and writes. Set, read
// and no-op commands, and steps at a zero or outside cursor, go from dispatch straight to
// the result. The single port of the cell memory serializes the sequence: neighbour reads
// and cell writes go one at a time. A new beat is accepted while the previous result
// still waits on the output.
module maze_carve_step_3d
	import mcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// command input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // cursor_x[4:0], cursor_y[9:5], cursor_z[14:10],
	                              // random_value[22:15], zero[23]
	input  logic [1:0]  s_tuser,  // command[1:0]
	// result output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // next_x[4:0], next_y[9:5], next_z[14:10],
	                              // open_mask[20:15], cell_value[21], zero[23:22]
	output logic [0:0]  m_tuser   // status[0]
);

	// sequencer codes
	localparam logic [3:0] ST_CLR   = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_ADR0  = 4'd2;
	localparam logic [3:0] ST_ADR1  = 4'd3;
	localparam logic [3:0] ST_DISP  = 4'd4;
	localparam logic [3:0] ST_PROBE = 4'd5;
	localparam logic [3:0] ST_PICK  = 4'd6;
	localparam logic [3:0] ST_SEL   = 4'd7;
	localparam logic [3:0] ST_WALL  = 4'd8;
	localparam logic [3:0] ST_TGT   = 4'd9;
	localparam logic [3:0] ST_FIN   = 4'd10;

	localparam logic [2:0] NUM_DIR = 3'd6;

	// direction codes, same order as the open mask bits
	localparam logic [2:0] DIR_XP = 3'd0;
	localparam logic [2:0] DIR_XM = 3'd1;
	localparam logic [2:0] DIR_YP = 3'd2;
	localparam logic [2:0] DIR_YM = 3'd3;
	localparam logic [2:0] DIR_ZP = 3'd4;
	localparam logic [2:0] DIR_ZM = 3'd5;

	// configuration registers
	logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
	logic              cfg_wr;

	// sequencer and item registers
	logic [3:0]         state_q;
	logic [ROW_AW-1:0]  clr_row_q;
	logic [1:0]         cmd_q;
	logic [COORD_W-1:0] cx_q, cy_q, cz_q;
	logic [7:0]         rnd_q;
	logic [10:0]        strz_q;
	logic [9:0]         zy_q;
	logic [ADDR_W-1:0]  base_q;
	logic [2:0]         k_q;
	logic               pend_s1;
	logic [2:0]         pdir_s1;
	logic               pinb_s1;
	logic [5:0]         mask_q;
	logic [2:0]         pick_q;
	logic [2:0]         dir_q;
	logic               dead_q;
	logic               moved_q;
	logic [COORD_W-1:0] nx_q, ny_q, nz_q;

	// output register
	logic        out_valid_q;
	logic [23:0] out_data_q;
	logic        out_status_q;

	// memory interface
	mem_req_t req;
	logic     rdata;

	// effective sizes and cursor checks
	logic [SIZE_W-1:0] ex, ey, ez;
	logic              cur_in_grid;
	logic              zero_cur;

	assign ex = (size_x_q > SIZE_W'(MAX_SIDE)) ? SIZE_W'(MAX_SIDE) : size_x_q;
	assign ey = (size_y_q > SIZE_W'(MAX_SIDE)) ? SIZE_W'(MAX_SIDE) : size_y_q;
	assign ez = (size_z_q > SIZE_W'(MAX_SIDE)) ? SIZE_W'(MAX_SIDE) : size_z_q;

	assign cur_in_grid = ({1'b0, cx_q} < ex) && ({1'b0, cy_q} < ey) && ({1'b0, cz_q} < ez);
	assign zero_cur    = (cx_q == '0) && (cy_q == '0) && (cz_q == '0);

	// config writes and reads
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_W'(31);
			size_y_q <= SIZE_W'(31);
			size_z_q <= SIZE_W'(31);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_SIZE_X: size_x_q <= pwdata[SIZE_W-1:0];
				REG_SIZE_Y: size_y_q <= pwdata[SIZE_W-1:0];
				REG_SIZE_Z: size_z_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_SIZE_X: prdata = {26'd0, size_x_q};
			REG_SIZE_Y: prdata = {26'd0, size_y_q};
			REG_SIZE_Z: prdata = {26'd0, size_z_q};
			default:    prdata = '0;
		endcase
	end

	// coordinate along one axis
	function automatic logic [COORD_W-1:0] axis_coord(input logic [1:0] a,
		input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
		input logic [COORD_W-1:0] z);
		logic [COORD_W-1:0] r;
		unique case (a)
			2'd0:    r = x;
			2'd1:    r = y;
			default: r = z;
		endcase
		return r;
	endfunction

	// neighbour in bounds for direction d
	logic [1:0]         p_axis;
	logic [COORD_W-1:0] p_c;
	logic [SIZE_W-1:0]  p_s;
	logic               p_inb;

	assign p_axis = k_q[2:1];
	assign p_c    = axis_coord(p_axis, cx_q, cy_q, cz_q);

	always_comb begin
		unique case (p_axis)
			2'd0:    p_s = ex;
			2'd1:    p_s = ey;
			default: p_s = ez;
		endcase
	end

	assign p_inb = k_q[0] ? (p_c >= COORD_W'(2)) : (({1'b0, p_c} + SIZE_W'(2)) < p_s);

	// linear address of the cell one or two steps away along direction d
	function automatic logic [ADDR_W-1:0] nb_addr(input logic [ADDR_W-1:0] base,
		input logic [2:0] d, input logic two, input logic [SIZE_W-1:0] sx,
		input logic [10:0] sz);
		logic [ADDR_W:0] stride;
		logic [ADDR_W:0] off;
		logic [ADDR_W:0] sum;
		unique case (d[2:1])
			2'd0:    stride = (ADDR_W+1)'(1);
			2'd1:    stride = (ADDR_W+1)'(sx);
			default: stride = (ADDR_W+1)'(sz);
		endcase
		off = two ? (stride << 1) : stride;
		sum = d[0] ? ({1'b0, base} - off) : ({1'b0, base} + off);
		return sum[ADDR_W-1:0];
	endfunction

	// n mod d for d from 1 to 6, by reciprocal multiplication for 3, 5 and 6
	function automatic logic [2:0] mod_small(input logic [7:0] n, input logic [2:0] d);
		logic [15:0] p3;
		logic [15:0] p5;
		logic [7:0]  q;
		logic [7:0]  r;
		p3 = 16'(n) * 16'd171;
		p5 = 16'(n) * 16'd205;
		q  = '0;
		r  = '0;
		unique case (d)
			3'd2: r = {7'd0, n[0]};
			3'd3: begin
				q = 8'(p3 >> 9);
				r = n - (q + (q << 1));
			end
			3'd4: r = {6'd0, n[1:0]};
			3'd5: begin
				q = 8'(p5 >> 10);
				r = n - (q + (q << 2));
			end
			3'd6: begin
				q = 8'(p3 >> 10);
				r = n - ((q << 1) + (q << 2));
			end
			default: r = '0;
		endcase
		return r[2:0];
	endfunction

	// available direction count and pick-th set bit
	logic [2:0] mask_cnt;
	logic [2:0] sel_dir;

	always_comb begin
		mask_cnt = '0;
		for (int i = 0; i < 6; i++) begin
			mask_cnt = mask_cnt + 3'(mask_q[i]);
		end
	end

	always_comb begin
		logic [2:0] left;
		logic       found;
		left    = pick_q;
		found   = 1'b0;
		sel_dir = '0;
		for (int i = 0; i < 6; i++) begin
			if (mask_q[i] && !found) begin
				if (left == '0) begin
					sel_dir = 3'(i);
					found   = 1'b1;
				end else begin
					left = left - 3'd1;
				end
			end
		end
	end

	// memory request per state
	always_comb begin
		req = '0;
		unique case (state_q)
			ST_CLR: begin
				req.clr  = 1'b1;
				req.addr = {clr_row_q, {BIT_W{1'b0}}};
			end
			ST_DISP: begin
				req.addr = base_q;
				req.set  = (cmd_q == CMD_SET) && cur_in_grid;
				req.rd   = (cmd_q == CMD_READ) && cur_in_grid;
			end
			ST_PROBE: begin
				req.addr = nb_addr(base_q, k_q, 1'b1, ex, strz_q);
				req.rd   = (k_q < NUM_DIR);
			end
			ST_WALL: begin
				req.addr = nb_addr(base_q, dir_q, 1'b0, ex, strz_q);
				req.set  = 1'b1;
			end
			ST_TGT: begin
				req.addr = nb_addr(base_q, dir_q, 1'b1, ex, strz_q);
				req.set  = 1'b1;
			end
			default: req = '0;
		endcase
	end

	mcs_cell_ram u_ram (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	assign s_tready = (state_q == ST_IDLE);

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_row_q <= '0;
			k_q       <= '0;
			pend_s1   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_row_q <= clr_row_q + ROW_AW'(1);
					if (clr_row_q == ROW_AW'(ROW_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_ADR0;
					end
				end
				ST_ADR0: state_q <= ST_ADR1;
				ST_ADR1: state_q <= ST_DISP;
				ST_DISP: begin
					k_q     <= '0;
					pend_s1 <= 1'b0;
					if (cmd_q == CMD_STEP && !zero_cur && cur_in_grid) begin
						state_q <= ST_PROBE;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_PROBE: begin
					pend_s1 <= (k_q < NUM_DIR);
					if (k_q < NUM_DIR) begin
						k_q <= k_q + 3'd1;
					end else begin
						state_q <= ST_PICK;
					end
				end
				ST_PICK: state_q <= (mask_cnt == '0) ? ST_FIN : ST_SEL;
				ST_SEL:  state_q <= ST_WALL;
				ST_WALL: state_q <= ST_TGT;
				ST_TGT:  state_q <= ST_FIN;
				ST_FIN: begin
					if (!out_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cmd_q   <= s_tuser;
				cx_q    <= s_tdata[4:0];
				cy_q    <= s_tdata[9:5];
				cz_q    <= s_tdata[14:10];
				rnd_q   <= s_tdata[22:15];
				mask_q  <= '0;
				dead_q  <= 1'b0;
				moved_q <= 1'b0;
			end
			ST_ADR0: begin
				strz_q <= 11'(ex * ey);
				zy_q   <= 10'(cz_q * ey) + 10'(cy_q);
			end
			ST_ADR1: base_q <= ADDR_W'(zy_q * ex) + ADDR_W'(cx_q);
			ST_DISP: begin
				dead_q <= (cmd_q == CMD_STEP) && (zero_cur || !cur_in_grid);
			end
			ST_PROBE: begin
				pdir_s1 <= k_q;
				pinb_s1 <= p_inb;
				if (pend_s1) begin
					mask_q[pdir_s1] <= pinb_s1 && !rdata;
				end
			end
			ST_PICK: begin
				pick_q <= mod_small(rnd_q, mask_cnt);
				dead_q <= (mask_cnt == '0);
			end
			ST_SEL: dir_q <= sel_dir;
			ST_TGT: begin
				moved_q <= 1'b1;
				nx_q    <= (dir_q == DIR_XP) ? cx_q + COORD_W'(2)
					: (dir_q == DIR_XM) ? cx_q - COORD_W'(2) : cx_q;
				ny_q    <= (dir_q == DIR_YP) ? cy_q + COORD_W'(2)
					: (dir_q == DIR_YM) ? cy_q - COORD_W'(2) : cy_q;
				nz_q    <= (dir_q == DIR_ZP) ? cz_q + COORD_W'(2)
					: (dir_q == DIR_ZM) ? cz_q - COORD_W'(2) : cz_q;
			end
			default: ;
		endcase
	end

	// result beat register
	logic fin_load;
	logic cell_bit;

	assign fin_load = (state_q == ST_FIN) && (!out_valid_q || m_tready);
	assign cell_bit = (cmd_q == CMD_READ) && cur_in_grid && rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			out_status_q <= dead_q;
			if (moved_q) begin
				out_data_q <= {2'b00, cell_bit, mask_q, nz_q, ny_q, nx_q};
			end else begin
				out_data_q <= {2'b00, cell_bit, 21'd0};
			end
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_status_q;

	// checks
	a_set_only_in_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		req.set |-> (state_q == ST_DISP || state_q == ST_WALL || state_q == ST_TGT))
		else $error("cell set outside a write state");

	a_chosen_dir_available: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALL) |-> mask_q[dir_q])
		else $error("carve direction not among the available ones");

	a_dead_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[21:0] == 22'd0))
		else $error("dead end result carries payload");

	a_no_accept_during_clear: assert property (@(posedge clk) disable iff (!arst_n)
		req.clr |-> !s_tready)
		else $error("beat accepted while memory is being cleared");

	a_probe_ends_in_pick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE && k_q == NUM_DIR) |=> (state_q == ST_PICK))
		else $error("probe sequence did not finish in pick");

endmodule
